FILE: design/alsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alsp_pkg
// shared constants and controller/datapath handshake types for the
// sequential list block
// ----------------------------------------------------------------------------
package alsp_pkg;

    localparam int CAPACITY_DEF = 128;
    localparam int WORD_W       = 32;
    localparam int POS_W        = 8;
    localparam int COUNT_W      = 8;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_PART   = 2'd2;
    localparam logic [1:0] CMD_READ   = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_POS  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic take;
        logic load;
        logic pass2;
        logic rd_issue;
        logic ins_wr;
        logic cnt_dec;
        logic respond;
    } alsp_ctl_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic [1:0] code;
        logic       no_shift;
        logic       empty;
        logic       at_end;
        logic       pass2;
        logic       out_free;
    } alsp_sts_t;

endpackage

FILE: design/alsp_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alsp_req_if
// command channel: valid/ready with command, position and value
// ----------------------------------------------------------------------------
interface alsp_req_if;
    logic                                  valid;
    logic                                  ready;
    logic [1:0]                            command;
    logic [alsp_pkg::POS_W-1:0]            position;
    logic signed [alsp_pkg::WORD_W-1:0]    value;

    modport source (output valid, output command, output position, output value,
                    input ready);
    modport sink   (input valid, input command, input position, input value,
                    output ready);
endinterface

FILE: design/alsp_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alsp_rsp_if
// response channel: valid/ready with status, data and count
// ----------------------------------------------------------------------------
interface alsp_rsp_if;
    logic                                  valid;
    logic                                  ready;
    logic [1:0]                            status;
    logic signed [alsp_pkg::WORD_W-1:0]    data;
    logic [alsp_pkg::COUNT_W-1:0]          count;

    modport source (output valid, output status, output data, output count,
                    input ready);
    modport sink   (input valid, input status, input data, input count,
                    output ready);
endinterface

FILE: design/alsp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alsp_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module alsp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/alsp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alsp_ctrl
// command sequencer: check, scan the ram one word per cycle, respond
// ----------------------------------------------------------------------------
module alsp_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                ready,
    input  alsp_pkg::alsp_sts_t sts,
    output alsp_pkg::alsp_ctl_t ctl
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_PLOAD = 3'd4;
    localparam logic [2:0] S_INSWR = 3'd5;
    localparam logic [2:0] S_RESP  = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                ctl.take = in_valid;
                if (in_valid)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                ctl.load = 1'b1;
                if (sts.code != alsp_pkg::ST_OK)
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    unique case (sts.cmd) inside
                        alsp_pkg::CMD_INSERT:
                            state_next = sts.no_shift ? S_INSWR : S_SCAN;
                        alsp_pkg::CMD_PART:
                            state_next = sts.empty ? S_RESP : S_SCAN;
                        alsp_pkg::CMD_DELETE, alsp_pkg::CMD_READ:
                            state_next = S_SCAN;
                        default:
                            state_next = S_RESP;
                    endcase
                end
            end
            S_SCAN:
            begin
                ctl.rd_issue = 1'b1;
                if (sts.at_end)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                unique case (sts.cmd)
                    alsp_pkg::CMD_INSERT:
                        state_next = S_INSWR;
                    alsp_pkg::CMD_DELETE:
                    begin
                        ctl.cnt_dec = 1'b1;
                        state_next  = S_RESP;
                    end
                    alsp_pkg::CMD_PART:
                        state_next = sts.pass2 ? S_RESP : S_PLOAD;
                    default:
                        state_next = S_RESP;
                endcase
            end
            S_PLOAD:
            begin
                ctl.load   = 1'b1;
                ctl.pass2  = 1'b1;
                state_next = S_SCAN;
            end
            S_INSWR:
            begin
                ctl.ins_wr = 1'b1;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (sts.out_free)
                begin
                    ctl.respond = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule

FILE: design/alsp_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alsp_dp
// list datapath: command registers, scan pointers, list and scratch rams,
// response register
// ----------------------------------------------------------------------------
module alsp_dp #(
    parameter int CAPACITY = alsp_pkg::CAPACITY_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  alsp_pkg::alsp_ctl_t                 ctl,
    output alsp_pkg::alsp_sts_t                 sts,
    input  logic [1:0]                          in_command,
    input  logic [alsp_pkg::POS_W-1:0]          in_position,
    input  logic signed [alsp_pkg::WORD_W-1:0]  in_value,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic [1:0]                          out_status,
    output logic signed [alsp_pkg::WORD_W-1:0]  out_data,
    output logic [alsp_pkg::COUNT_W-1:0]        out_count
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = ((CW > alsp_pkg::POS_W) ? CW : alsp_pkg::POS_W) + 1;
    localparam int WW = alsp_pkg::WORD_W;

    logic [1:0]                  cmd_reg;
    logic [alsp_pkg::POS_W-1:0]  pos_reg;
    logic [WW-1:0]               val_reg;
    logic [CW-1:0]               count_reg;
    logic [1:0]                  code_reg;
    logic [AW-1:0]               src_reg;
    logic [AW-1:0]               end_reg;
    logic                        down_reg;
    logic                        pass2_reg;
    logic                        first_reg;
    logic [CW-1:0]               front_reg;
    logic [CW-1:0]               back_reg;
    logic                        pipe_vld_reg;
    logic [AW-1:0]               pipe_src_reg;
    logic                        pipe_first_reg;
    logic [WW-1:0]               word_reg;
    logic                        out_vld_reg;
    logic [1:0]                  out_status_reg;
    logic [WW-1:0]               out_data_reg;
    logic [alsp_pkg::COUNT_W-1:0] out_count_reg;

    logic [PW-1:0] pos_x;
    logic [PW-1:0] cnt_x;
    logic [PW-1:0] pm1;
    logic [PW-1:0] cm1;
    logic          ins_bad;
    logic          acc_bad;
    logic          full;
    logic [1:0]    code;
    logic [AW-1:0] src_init;
    logic [AW-1:0] end_init;
    logic          is_fetch;

    logic          list_we;
    logic [AW-1:0] list_waddr;
    logic [WW-1:0] list_wdata;
    logic [WW-1:0] list_rdata;
    logic          scr_we;
    logic [AW-1:0] scr_waddr;
    logic [WW-1:0] scr_rdata;
    logic [CW-1:0] back_m1;
    logic          neg;

    assign pos_x   = {{(PW - alsp_pkg::POS_W){1'b0}}, pos_reg};
    assign cnt_x   = {{(PW - CW){1'b0}}, count_reg};
    assign pm1     = pos_x - PW'(1);
    assign cm1     = cnt_x - PW'(1);
    assign ins_bad = (pos_x == '0) || (pos_x > (cnt_x + PW'(1)));
    assign acc_bad = (pos_x == '0) || (pos_x > cnt_x);
    assign full    = (cnt_x == PW'(CAPACITY));
    assign is_fetch = (cmd_reg == alsp_pkg::CMD_DELETE) || (cmd_reg == alsp_pkg::CMD_READ);

    always_comb
    begin
        code     = alsp_pkg::ST_OK;
        src_init = '0;
        end_init = cm1[AW-1:0];
        unique case (cmd_reg)
            alsp_pkg::CMD_INSERT:
            begin
                code     = ins_bad ? alsp_pkg::ST_POS :
                           (full ? alsp_pkg::ST_FULL : alsp_pkg::ST_OK);
                src_init = cm1[AW-1:0];
                end_init = pm1[AW-1:0];
            end
            alsp_pkg::CMD_DELETE:
            begin
                code     = acc_bad ? alsp_pkg::ST_POS : alsp_pkg::ST_OK;
                src_init = pm1[AW-1:0];
                end_init = cm1[AW-1:0];
            end
            alsp_pkg::CMD_READ:
            begin
                code     = acc_bad ? alsp_pkg::ST_POS : alsp_pkg::ST_OK;
                src_init = pm1[AW-1:0];
                end_init = pm1[AW-1:0];
            end
            default:
            begin
                code     = alsp_pkg::ST_OK;
                src_init = '0;
                end_init = cm1[AW-1:0];
            end
        endcase
    end

    assign sts.cmd      = cmd_reg;
    assign sts.code     = code;
    assign sts.no_shift = (pos_x == (cnt_x + PW'(1)));
    assign sts.empty    = (count_reg == '0);
    assign sts.at_end   = (src_reg == end_reg);
    assign sts.pass2    = pass2_reg;
    assign sts.out_free = !out_vld_reg || out_ready;

    // count and the read-pipe and response valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            pipe_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            pipe_vld_reg <= ctl.rd_issue;
            if (ctl.ins_wr)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (ctl.cnt_dec)
            begin
                count_reg <= count_reg - CW'(1);
            end
            if (ctl.respond)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    assign back_m1 = back_reg - CW'(1);
    assign neg     = list_rdata[WW-1];

    always_ff @(posedge clk)
    begin
        if (ctl.take)
        begin
            cmd_reg <= in_command;
            pos_reg <= in_position;
            val_reg <= in_value;
        end
        if (ctl.load)
        begin
            code_reg  <= code;
            src_reg   <= ctl.pass2 ? '0 : src_init;
            end_reg   <= ctl.pass2 ? cm1[AW-1:0] : end_init;
            down_reg  <= (cmd_reg == alsp_pkg::CMD_INSERT);
            pass2_reg <= ctl.pass2;
            first_reg <= 1'b1;
            front_reg <= '0;
            back_reg  <= count_reg;
        end
        else if (ctl.rd_issue)
        begin
            first_reg <= 1'b0;
            if (src_reg != end_reg)
            begin
                src_reg <= down_reg ? (src_reg - AW'(1)) : (src_reg + AW'(1));
            end
        end
        if (ctl.rd_issue)
        begin
            pipe_src_reg   <= src_reg;
            pipe_first_reg <= first_reg;
        end
        if (scr_we)
        begin
            if (neg)
            begin
                front_reg <= front_reg + CW'(1);
            end
            else
            begin
                back_reg <= back_m1;
            end
        end
        if (pipe_vld_reg && pipe_first_reg && is_fetch)
        begin
            word_reg <= list_rdata;
        end
        if (ctl.respond)
        begin
            out_status_reg <= code_reg;
            out_data_reg   <= ((code_reg == alsp_pkg::ST_OK) && is_fetch) ? word_reg : '0;
            out_count_reg  <= cnt_x[alsp_pkg::COUNT_W-1:0];
        end
    end

    // ram write ports
    always_comb
    begin
        list_we    = 1'b0;
        list_waddr = pipe_src_reg;
        list_wdata = list_rdata;
        scr_we     = 1'b0;
        scr_waddr  = neg ? front_reg[AW-1:0] : back_m1[AW-1:0];
        if (ctl.ins_wr)
        begin
            list_we    = 1'b1;
            list_waddr = pm1[AW-1:0];
            list_wdata = val_reg;
        end
        else if (pipe_vld_reg)
        begin
            case (cmd_reg)
                alsp_pkg::CMD_INSERT:
                begin
                    list_we    = 1'b1;
                    list_waddr = pipe_src_reg + AW'(1);
                end
                alsp_pkg::CMD_DELETE:
                begin
                    list_we    = !pipe_first_reg;
                    list_waddr = pipe_src_reg - AW'(1);
                end
                alsp_pkg::CMD_PART:
                begin
                    if (pass2_reg)
                    begin
                        list_we    = 1'b1;
                        list_wdata = scr_rdata;
                    end
                    else
                    begin
                        scr_we = 1'b1;
                    end
                end
                default:
                begin
                    list_we = 1'b0;
                end
            endcase
        end
    end

    alsp_ram #(
        .WIDTH (WW),
        .DEPTH (CAPACITY)
    ) u_list_ram (
        .clk   (clk),
        .we    (list_we),
        .waddr (list_waddr),
        .wdata (list_wdata),
        .raddr (src_reg),
        .rdata (list_rdata)
    );

    alsp_ram #(
        .WIDTH (WW),
        .DEPTH (CAPACITY)
    ) u_scratch_ram (
        .clk   (clk),
        .we    (scr_we),
        .waddr (scr_waddr),
        .wdata (list_rdata),
        .raddr (src_reg),
        .rdata (scr_rdata)
    );

    assign out_valid  = out_vld_reg;
    assign out_status = out_status_reg;
    assign out_data   = out_data_reg;
    assign out_count  = out_count_reg;

endmodule

FILE: design/array_list_insert_delete_sign_partition.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_list_insert_delete_sign_partition
// fixed-capacity list of signed 32-bit words with insert, delete, read and
// sign partition
// ----------------------------------------------------------------------------
// One command is worked on at a time; req is ready only while the sequencer
// is idle, and a finished response may wait in its output register while the
// next command is taken. The list and the scratch area are RAMs with one
// write and one registered read port, and every word moved goes through them
// one per cycle. Insert at position p of a list of n words shifts the words
// from p to n up by one (appending at the end shifts none), delete shifts the
// words after p down by one, read fetches a single word, and partition makes
// one pass into the scratch RAM and one pass back; a rejected command or a
// partition of an empty list skips the scan.
// The RAMs need no clearing after reset.
module array_list_insert_delete_sign_partition #(
    parameter int CAPACITY = alsp_pkg::CAPACITY_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    alsp_req_if.sink   req,
    alsp_rsp_if.source rsp
);

    alsp_pkg::alsp_ctl_t ctl;
    alsp_pkg::alsp_sts_t sts;
    logic                ready;

    assign req.ready = ready;

    alsp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .ready    (ready),
        .sts      (sts),
        .ctl      (ctl)
    );

    alsp_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .sts         (sts),
        .in_command  (req.command),
        .in_position (req.position),
        .in_value    (req.value),
        .out_ready   (rsp.ready),
        .out_valid   (rsp.valid),
        .out_status  (rsp.status),
        .out_data    (rsp.data),
        .out_count   (rsp.count)
    );

endmodule
